/* hw/rtl/nplw_pkg.sv */
package nplw_pkg;

  // Default upper bound on the page-size exponent.
  localparam int MAX_PAGE_SHIFT_DEF = 16;
  // Smallest page-size exponent the walker honours.
  localparam int MIN_PAGE_SHIFT = 12;
  // Depth of the job queue between the front and back parts.
  localparam int JOB_DEPTH_DEF = 2;

  localparam int ADDR_W = 64;
  localparam int LEN_W = 17;
  localparam int XFER_W = 32;
  localparam int COV_W = 33;
  localparam int WORDS_W = 14;
  localparam int SHIFT_W = 5;
  localparam int ENTRY_BYTES = 8;
  localparam int ENTRY_SHIFT = 3;
  localparam int WORDS_MAX = 16383;

  typedef enum logic [1:0] {
    KIND_REGION = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_WORD  = 1'b1
  } opcode_t;

  // One result as it leaves the block, without its last flag.
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [LEN_W-1:0]   length;
    logic               final_res;
  } res_t;

  // Work handed from the front part to the back part: one or two results.
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } job_t;

endpackage

/* hw/rtl/nvme_prp_list_walker.sv */
// NVMe PRP walker. A start command (opcode 0) carries the command's two data
// pointers and its transfer length; each fetched list word (opcode 1) arrives
// as an item of its own. The block returns physical regions, each running
// from its address to the end of its memory page, list fetch requests and
// error markers, with last set on the final result of each input item and
// final_res on the region that completes the walk. The page size is taken
// from cfg_data when cfg_write is high, clamped to the range from 2^12 up to
// 2^MAX_PAGE_SHIFT bytes, and must only be changed while the block is idle.
// Input items are classified by the front part in the cycle of their
// transfer, so one item is taken every clock unless the job queue is full.
// Items that yield a single result leave at one per cycle while pop is held;
// a start command that yields two results occupies the output stage for two
// transfers, and the job queue (JOB_DEPTH entries) absorbs the difference.
// A result passes a queue slot and the back part's job register on its way out,
// and a waiting result never stops new items being taken while there is room.
module nvme_prp_list_walker
  import nplw_pkg::*;
#(
  parameter int MAX_PAGE_SHIFT = MAX_PAGE_SHIFT_DEF,
  parameter int JOB_DEPTH      = JOB_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [SHIFT_W-1:0]  cfg_data,
  input  logic                push,
  output logic                full,
  input  logic                opcode,
  input  logic [ADDR_W-1:0]   first_pointer,
  input  logic [ADDR_W-1:0]   second_pointer,
  input  logic [XFER_W-1:0]   transfer_bytes,
  input  logic [ADDR_W-1:0]   list_entry,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind,
  output logic [ADDR_W-1:0]   address,
  output logic [LEN_W-1:0]    length,
  output logic                final_res,
  output logic                last
);

  logic  accept;
  logic  job_push;
  job_t  job_new;
  logic  q_full;
  logic  q_valid;
  job_t  q_job;
  logic  q_take;

  // An input transfer happens when push is high and the job queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Front part: walk state, page arithmetic and result classification.
  nplw_front #(
    .MAX_PAGE_SHIFT (MAX_PAGE_SHIFT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .opcode         (opcode),
    .first_pointer  (first_pointer),
    .second_pointer (second_pointer),
    .transfer_bytes (transfer_bytes),
    .list_entry     (list_entry),
    .job_push       (job_push),
    .job            (job_new)
  );

  // Short queue so that the front and back parts stall independently.
  nplw_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (job_push),
    .wr_job   (job_new),
    .full     (q_full),
    .rd       (q_take),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  // Back part: holds the current job and hands out its results in order.
  nplw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_in    (q_job),
    .job_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .address   (address),
    .length    (length),
    .final_res (final_res),
    .last      (last)
  );

endmodule

/* hw/rtl/nplw_front.sv */
module nplw_front
  import nplw_pkg::*;
#(
  parameter int MAX_PAGE_SHIFT = MAX_PAGE_SHIFT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [SHIFT_W-1:0]  cfg_data,
  input  logic                accept,
  input  logic                opcode,
  input  logic [ADDR_W-1:0]   first_pointer,
  input  logic [ADDR_W-1:0]   second_pointer,
  input  logic [XFER_W-1:0]   transfer_bytes,
  input  logic [ADDR_W-1:0]   list_entry,
  output logic                job_push,
  output job_t                job
);

  // Page sizes up to 2^MAX_PAGE_SHIFT need one bit more than the exponent.
  localparam int RW = MAX_PAGE_SHIFT + 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LIST,
    PH_SKIP
  } phase_t;

  phase_t               phase, phase_next;
  logic [XFER_W-1:0]    requested_bytes, requested_next;
  logic [COV_W-1:0]     covered_bytes, covered_next;
  logic [WORDS_W-1:0]   words_left, words_next;
  logic [RW-1:0]        page_bytes, page_bytes_next;

  logic [RW-1:0]        page_mask;
  logic [RW-1:0]        s1, s2, sz;
  logic [RW:0]          s_pair;
  logic [WORDS_W-1:0]   words_dec;
  logic [COV_W-1:0]     covered_sum;
  logic [SHIFT_W-1:0]   shift_eff;

  function automatic logic [LEN_W-1:0] to_len(input logic [RW-1:0] r);
    logic [RW+LEN_W-1:0] wide;
    wide = {{LEN_W{1'b0}}, r};
    return wide[LEN_W-1:0];
  endfunction

  // Words in a fetch of the given length, rounded up and saturated.
  function automatic logic [WORDS_W-1:0] word_count(input logic [RW-1:0] s);
    logic [RW:0] t;
    logic [RW:0] w;
    t = {1'b0, s} + (RW+1)'(ENTRY_BYTES - 1);
    w = t >> ENTRY_SHIFT;
    if (w > (RW+1)'(WORDS_MAX)) begin
      return WORDS_W'(WORDS_MAX);
    end
    return WORDS_W'(w);
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [ADDR_W-1:0] a,
                                  input logic [RW-1:0] l, input logic f);
    res_t r;
    r.kind      = k;
    r.address   = a;
    r.length    = to_len(l);
    r.final_res = f;
    return r;
  endfunction

  assign page_mask   = page_bytes - RW'(1);
  assign s1          = page_bytes - (first_pointer[RW-1:0] & page_mask);
  assign s2          = page_bytes - (second_pointer[RW-1:0] & page_mask);
  assign sz          = page_bytes - (list_entry[RW-1:0] & page_mask);
  assign s_pair      = {1'b0, s1} + {1'b0, s2};
  assign words_dec   = words_left - WORDS_W'(1);
  assign covered_sum = covered_bytes + COV_W'(sz);

  // The page-size exponent is clamped when written.
  always_comb begin
    if (cfg_data < SHIFT_W'(MIN_PAGE_SHIFT)) begin
      shift_eff = SHIFT_W'(MIN_PAGE_SHIFT);
    end else if (cfg_data > SHIFT_W'(MAX_PAGE_SHIFT)) begin
      shift_eff = SHIFT_W'(MAX_PAGE_SHIFT);
    end else begin
      shift_eff = cfg_data;
    end
    page_bytes_next = cfg_write ? (RW'(1) << shift_eff) : page_bytes;
  end

  always_comb begin
    phase_next     = phase;
    requested_next = requested_bytes;
    covered_next   = covered_bytes;
    words_next     = words_left;
    job_push       = 1'b0;
    job            = '0;
    job.first      = mk_res(KIND_ERROR, '0, '0, 1'b0);
    if (accept) begin
      if (opcode == OP_START) begin
        job_push       = 1'b1;
        requested_next = transfer_bytes;
        covered_next   = '0;
        words_next     = '0;
        phase_next     = PH_IDLE;
        if (first_pointer == '0) begin
          // No first region, but its page still counts as covered.
          covered_next = COV_W'(s1);
          words_next   = word_count(s2);
          phase_next   = PH_LIST;
          job.first    = mk_res(KIND_FETCH, second_pointer, s2, 1'b0);
        end else if (transfer_bytes <= XFER_W'(page_bytes) &&
                     transfer_bytes <= XFER_W'(s1)) begin
          covered_next = COV_W'(s1);
          job.first    = mk_res(KIND_REGION, first_pointer, s1, 1'b1);
        end else if (transfer_bytes <= XFER_W'(page_bytes) ||
                     (transfer_bytes <= XFER_W'({page_bytes, 1'b0}) &&
                      s1 == page_bytes)) begin
          if (XFER_W'(s_pair) < transfer_bytes) begin
            job.first = mk_res(KIND_ERROR, '0, '0, 1'b0);
          end else begin
            requested_next = XFER_W'(s_pair);
            covered_next   = COV_W'(s_pair);
            job.two        = 1'b1;
            job.first      = mk_res(KIND_REGION, first_pointer, s1, 1'b0);
            job.second     = mk_res(KIND_REGION, second_pointer, s2, 1'b1);
          end
        end else begin
          covered_next = COV_W'(s1);
          words_next   = word_count(s2);
          phase_next   = PH_LIST;
          job.two      = 1'b1;
          job.first    = mk_res(KIND_REGION, first_pointer, s1, 1'b0);
          job.second   = mk_res(KIND_FETCH, second_pointer, s2, 1'b0);
        end
      end else if (phase == PH_SKIP) begin
        // Rest of a fetch after the walk completed: absorbed silently.
        if (words_left != '0) begin
          words_next = words_dec;
        end
        if (words_left == '0 || words_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end else if (phase != PH_LIST || words_left == '0) begin
        job_push   = 1'b1;
        phase_next = PH_IDLE;
        words_next = '0;
      end else if (list_entry == '0) begin
        job_push   = 1'b1;
        phase_next = PH_IDLE;
        words_next = '0;
      end else begin
        job_push   = 1'b1;
        words_next = words_dec;
        if (covered_sum >= COV_W'(requested_bytes)) begin
          covered_next = covered_sum;
          phase_next   = (words_dec == '0) ? PH_IDLE : PH_SKIP;
          job.first    = mk_res(KIND_REGION, list_entry, sz, 1'b1);
        end else if (words_dec == '0) begin
          // The last word of a fetch points to the next list page.
          words_next = word_count(sz);
          job.first  = mk_res(KIND_FETCH, list_entry, sz, 1'b0);
        end else begin
          covered_next = covered_sum;
          job.first    = mk_res(KIND_REGION, list_entry, sz, 1'b0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      requested_bytes <= '0;
      covered_bytes   <= '0;
      words_left      <= '0;
      page_bytes      <= RW'(1) << MIN_PAGE_SHIFT;
    end else begin
      phase           <= phase_next;
      requested_bytes <= requested_next;
      covered_bytes   <= covered_next;
      words_left      <= words_next;
      page_bytes      <= page_bytes_next;
    end
  end

endmodule

/* hw/rtl/nplw_queue.sv */
module nplw_queue
  import nplw_pkg::*;
#(
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  job_t  wr_job,
  output logic  full,
  input  logic  rd,
  output logic  rd_valid,
  output job_t  rd_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t           slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hw/rtl/nplw_back.sv */
module nplw_back
  import nplw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job_in,
  output logic               job_take,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic [ADDR_W-1:0]  address,
  output logic [LEN_W-1:0]   length,
  output logic               final_res,
  output logic               last
);

  logic  busy;
  logic  sel;
  job_t  job;
  res_t  cur;
  logic  done, advance;

  assign cur       = sel ? job.second : job.first;
  assign empty     = !busy;
  assign kind      = cur.kind;
  assign address   = cur.address;
  assign length    = cur.length;
  assign final_res = cur.final_res;
  assign last      = sel || !job.two;

  assign advance  = pop && busy && !sel && job.two;
  assign done     = pop && busy && (sel || !job.two);
  assign job_take = job_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (job_take) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= 1'b0;
    end else if (advance) begin
      sel <= 1'b1;
    end else if (!busy || done) begin
      busy <= job_valid;
      sel  <= 1'b0;
    end
  end

endmodule
